// ===== hw/rtl/graph_stack_traversal_assert.svh =====
// Assertion macros for the graph stack traversal block.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef GRAPH_STACK_TRAVERSAL_ASSERT_SVH
`define GRAPH_STACK_TRAVERSAL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GST_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GST_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/gst_pkg.sv =====
// Shared types and codes of the graph stack traversal block.
// Used by the output register and the top level; depends on nothing.
package gst_pkg;

	localparam int unsigned FIELD_W = 6;

	typedef enum logic [1:0] {
		ST_VERTEX  = 2'd0,
		ST_EDGE_OK = 2'd1,
		ST_FULL    = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	typedef enum logic {
		CMD_ADD      = 1'b0,
		CMD_TRAVERSE = 1'b1
	} command_t;

	typedef struct packed {
		logic [FIELD_W-1:0] vertex;
		status_t            status;
		logic               last;
	} result_t;

endpackage

// ===== hw/rtl/gst_out_reg.sv =====
// Output register that holds one result request until the receiver takes it.
// Depends on gst_pkg for the result type.
module gst_out_reg
	import gst_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load_valid,
	output logic    load_ready,
	input  result_t load_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    valid_q;
	result_t data_q;

	assign load_ready = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_data   = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_valid && load_ready) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			data_q <= load_data;
		end
	end

endmodule

// ===== hw/rtl/graph_stack_traversal.sv =====
// Top level of the graph stack traversal block: sequencer and state memories.
// Depends on gst_pkg, gst_out_reg and graph_stack_traversal_assert.svh.
//
// Usage: the input channel carries requests (command, first_vertex,
// second_vertex); the output channel returns results (visited_vertex,
// status, last); the configuration channel writes vertex_limit from cfg_data
// and is always ready. A stored edge passes through S_E_WRA, S_E_RDB and
// S_E_WRB before S_EMIT loads its result into the output register; a rejected
// request goes straight to S_EMIT. A traverse request yields one result per
// reached vertex in depth-first order, the last one flagged. Each emitted
// vertex passes S_T_POP, S_T_HEAD and S_T_LINK, then S_T_SCAN and S_T_ENTRY
// per adjacency entry, then S_EMIT; reads of the list heads, the adjacency
// and stack memories are registered. Only one request is worked on at a
// time; a new request is accepted once the previous one has loaded its final
// result into the output register, even if the receiver has not yet taken
// it. When the receiver stalls, the sequencer waits with its next result.
// Reset empties all lists, clears the entry count, the visited marks and the
// stack, and sets vertex_limit to 63; no memory clearing pass is needed.
`include "graph_stack_traversal_assert.svh"

module graph_stack_traversal
	import gst_pkg::*;
#(
	parameter int unsigned MAX_VERTICES = 64,
	parameter int unsigned MAX_ENTRIES  = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic [FIELD_W-1:0] first_vertex,
	input  logic [FIELD_W-1:0] second_vertex,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [FIELD_W-1:0] visited_vertex,
	output logic [1:0]         status,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [FIELD_W-1:0] cfg_data
);

	localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int unsigned DW = $clog2(MAX_VERTICES + 1);
	localparam int unsigned EW = $clog2(MAX_ENTRIES);
	localparam int unsigned LW = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned AW = VW + LW;

	typedef enum logic [9:0] {
		S_IDLE    = 10'b00_0000_0001,
		S_E_WRA   = 10'b00_0000_0010,
		S_E_RDB   = 10'b00_0000_0100,
		S_E_WRB   = 10'b00_0000_1000,
		S_T_POP   = 10'b00_0001_0000,
		S_T_HEAD  = 10'b00_0010_0000,
		S_T_LINK  = 10'b00_0100_0000,
		S_T_SCAN  = 10'b00_1000_0000,
		S_T_ENTRY = 10'b01_0000_0000,
		S_EMIT    = 10'b10_0000_0000
	} state_t;

	state_t            state_q;
	logic [FIELD_W-1:0] vertex_limit_q;
	logic [FIELD_W-1:0] lim;
	logic [LW-1:0]     used_q;
	logic [LW-1:0]     used_p1;
	logic [LW-1:0]     used_p2;
	logic [DW-1:0]     depth_q;
	logic [DW-1:0]     depth_m1;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [MAX_VERTICES-1:0] head_vld_q;
	logic [VW-1:0]     a_q;
	logic [VW-1:0]     b_q;
	logic [VW-1:0]     cur_v_q;
	logic [LW-1:0]     link_q;
	logic [LW-1:0]     link_m1;
	result_t           res_q;

	logic [LW-1:0] head_mem [MAX_VERTICES];
	logic [AW-1:0] adj_mem  [MAX_ENTRIES];
	logic [VW-1:0] stk_mem  [MAX_VERTICES];

	logic [LW-1:0] head_rd_q;
	logic          head_rd_vld_q;
	logic [AW-1:0] adj_rd_q;
	logic [VW-1:0] stk_rd_q;

	logic [VW-1:0] head_rd_addr;
	logic          head_we;
	logic [VW-1:0] head_wr_addr;
	logic [LW-1:0] head_wr_data;
	logic          adj_we;
	logic [EW-1:0] adj_wr_addr;
	logic [AW-1:0] adj_wr_data;
	logic [EW-1:0] adj_rd_addr;
	logic          stk_we;
	logic [VW-1:0] stk_wr_addr;
	logic [VW-1:0] stk_wr_data;
	logic [VW-1:0] stk_rd_addr;

	logic [LW-1:0] head_link;
	logic [VW-1:0] nb;
	logic [LW-1:0] nb_link;
	logic          push;
	logic          accept;
	logic          edge_range_err;
	logic          edge_full;
	logic          start_range_err;
	logic          load_ready;
	result_t       out_data;

	assign lim = (vertex_limit_q > FIELD_W'(MAX_VERTICES - 1))
		? FIELD_W'(MAX_VERTICES - 1) : vertex_limit_q;
	assign used_p1  = used_q + LW'(1);
	assign used_p2  = used_q + LW'(2);
	assign depth_m1 = depth_q - DW'(1);
	assign link_m1  = link_q - LW'(1);
	assign head_link = head_rd_vld_q ? head_rd_q : '0;
	assign nb      = adj_rd_q[AW-1:LW];
	assign nb_link = adj_rd_q[LW-1:0];
	assign push = (state_q == S_T_ENTRY) && (32'(nb) < MAX_VERTICES) && !visited_q[nb];

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign edge_range_err  = (first_vertex > lim) || (second_vertex > lim);
	assign edge_full       = ((LW+1)'(used_q) + (LW+1)'(2)) > (LW+1)'(MAX_ENTRIES);
	assign start_range_err = (first_vertex > lim);

	always_comb begin
		head_rd_addr = a_q;
		head_we      = 1'b0;
		head_wr_addr = a_q;
		head_wr_data = used_p1;
		adj_we       = 1'b0;
		adj_wr_addr  = used_q[EW-1:0];
		adj_wr_data  = {b_q, head_link};
		adj_rd_addr  = link_m1[EW-1:0];
		stk_we       = 1'b0;
		stk_wr_addr  = depth_q[VW-1:0];
		stk_wr_data  = nb;
		stk_rd_addr  = depth_m1[VW-1:0];
		unique case (state_q)
			S_IDLE: begin
				head_rd_addr = first_vertex[VW-1:0];
				stk_wr_addr  = '0;
				stk_wr_data  = first_vertex[VW-1:0];
				stk_we       = accept && (command == CMD_TRAVERSE) && !start_range_err;
			end
			S_E_WRA: begin
				head_we = 1'b1;
				adj_we  = 1'b1;
			end
			S_E_RDB: begin
				head_rd_addr = b_q;
			end
			S_E_WRB: begin
				head_we      = 1'b1;
				head_wr_addr = b_q;
				head_wr_data = used_p2;
				adj_we       = 1'b1;
				adj_wr_addr  = used_p1[EW-1:0];
				adj_wr_data  = {a_q, head_link};
			end
			S_T_HEAD: begin
				head_rd_addr = stk_rd_q;
			end
			S_T_ENTRY: begin
				stk_we = push;
			end
			S_T_POP, S_T_LINK, S_T_SCAN, S_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_wr_addr] <= head_wr_data;
		end
		head_rd_q <= head_mem[head_rd_addr];
		if (adj_we) begin
			adj_mem[adj_wr_addr] <= adj_wr_data;
		end
		adj_rd_q <= adj_mem[adj_rd_addr];
		if (stk_we) begin
			stk_mem[stk_wr_addr] <= stk_wr_data;
		end
		stk_rd_q <= stk_mem[stk_rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q    <= '0;
			head_rd_vld_q <= 1'b0;
		end else begin
			if (head_we) begin
				head_vld_q[head_wr_addr] <= 1'b1;
			end
			head_rd_vld_q <= head_vld_q[head_rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_limit_q <= 6'd63;
		end else if (cfg_valid && cfg_ready) begin
			vertex_limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			used_q    <= '0;
			depth_q   <= '0;
			visited_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (command == CMD_ADD) begin
							if (edge_range_err || edge_full) begin
								state_q <= S_EMIT;
							end else begin
								state_q <= S_E_WRA;
							end
						end else if (start_range_err) begin
							state_q <= S_EMIT;
						end else begin
							visited_q <= MAX_VERTICES'(1) << first_vertex[VW-1:0];
							depth_q <= DW'(1);
							state_q <= S_T_POP;
						end
					end
				end
				S_E_WRA: state_q <= S_E_RDB;
				S_E_RDB: state_q <= S_E_WRB;
				S_E_WRB: begin
					used_q  <= used_p2;
					state_q <= S_EMIT;
				end
				S_T_POP: begin
					depth_q <= depth_m1;
					state_q <= S_T_HEAD;
				end
				S_T_HEAD: state_q <= S_T_LINK;
				S_T_LINK: state_q <= S_T_SCAN;
				S_T_SCAN: begin
					if (link_q == '0) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_T_ENTRY;
					end
				end
				S_T_ENTRY: begin
					if (push) begin
						visited_q[nb] <= 1'b1;
						depth_q <= depth_q + DW'(1);
					end
					state_q <= S_T_SCAN;
				end
				S_EMIT: begin
					if (load_ready) begin
						state_q <= res_q.last ? S_IDLE : S_T_POP;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				a_q <= first_vertex[VW-1:0];
				b_q <= second_vertex[VW-1:0];
				res_q.vertex <= '0;
				res_q.last   <= 1'b1;
				if (command == CMD_ADD) begin
					res_q.status <= edge_range_err ? ST_RANGE : ST_FULL;
				end else begin
					res_q.status <= ST_RANGE;
				end
			end
			S_E_WRB: begin
				res_q.vertex <= '0;
				res_q.status <= ST_EDGE_OK;
				res_q.last   <= 1'b1;
			end
			S_T_HEAD: begin
				cur_v_q <= stk_rd_q;
			end
			S_T_LINK: begin
				link_q <= head_link;
			end
			S_T_SCAN: begin
				res_q.vertex <= FIELD_W'(cur_v_q);
				res_q.status <= ST_VERTEX;
				res_q.last   <= (depth_q == '0);
			end
			S_T_ENTRY: begin
				link_q <= nb_link;
			end
			S_E_WRA, S_E_RDB, S_T_POP, S_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	gst_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (state_q == S_EMIT),
		.load_ready (load_ready),
		.load_data  (res_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	assign visited_vertex = out_data.vertex;
	assign status         = out_data.status;
	assign last           = out_data.last;

	`GST_ASSERT_IMP(a_idle_stack_empty, state_q == S_IDLE, depth_q == '0,
		"stack is not empty while idle")
	`GST_ASSERT_IMP(a_used_bounded, 1'b1, (used_q[0] == 1'b0) && (used_q <= LW'(MAX_ENTRIES)),
		"adjacency entry count is odd or above capacity")
	`GST_ASSERT_IMP(a_vertex_last, (state_q == S_EMIT) && (res_q.status == ST_VERTEX),
		res_q.last == (depth_q == '0), "last flag disagrees with stack depth")
	`GST_ASSERT_NXT(a_edge_two_entries, state_q == S_E_WRB, used_q == $past(used_q) + LW'(2),
		"accepted edge did not take two entries")

endmodule
